[hw/rtl/gbsm_pkg.sv]
// shared constants and types for the blur and gradient block
`default_nettype none
package gbsm_pkg;

    localparam int PIX_W       = 8;
    localparam int BLUR_W      = 16;
    localparam int GRAD_W      = 18;
    localparam int MAG_W       = 19;
    localparam int COEF_W      = 16;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 48;
    localparam int IMG_W_W     = 11;
    localparam int IMG_H_W     = 13;
    localparam int ROW_W       = 12;
    localparam int OUT_TDATA_W = 72;
    localparam int FIFO_DEPTH  = 4;

    localparam int DEF_MAX_WIDTH = 1024;
    localparam int MIN_DIM       = 5;
    localparam int MAX_HEIGHT    = 4096;

    // register indexes on the config channel
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_ROW0    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_ROW1    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_ROW2    = 3'd4;

    localparam logic [IMG_W_W-1:0]    RST_IMAGE_WIDTH  = 11'd640;
    localparam logic [IMG_H_W-1:0]    RST_IMAGE_HEIGHT = 13'd480;
    localparam logic [CFG_DATA_W-1:0] RST_COEF_ROW0    = 48'd12555048014944;
    localparam logic [CFG_DATA_W-1:0] RST_COEF_ROW1    = 48'd7615497777965;
    localparam logic [CFG_DATA_W-1:0] RST_COEF_ROW2    = 48'd1700923247467;

    // classification of one pixel by the front end
    typedef struct packed {
        logic rpar;     // row parity, selects line store
        logic blur_en;  // a blurred value is produced
        logic sob_en;   // a gradient result is produced
        logic last;     // last pixel of the frame
    } t_flags;

    localparam int FLAGS_W = $bits(t_flags);

endpackage
`default_nettype wire

[hw/rtl/gbsm_fifo.sv]
// short item queue between front end and back end
`default_nettype none
module gbsm_fifo #(
    parameter int DATA_W = 8
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire logic [DATA_W-1:0] i_data,
    output logic                   o_full,
    input  wire logic              i_pop,
    output logic                   o_nempty,
    output logic [DATA_W-1:0]      o_data
);
    import gbsm_pkg::*;

    localparam int PW = $clog2(FIFO_DEPTH);
    localparam int CNTW = $clog2(FIFO_DEPTH + 1);

    logic [DATA_W-1:0] r_mem [FIFO_DEPTH];
    logic [PW-1:0]     r_wptr, r_rptr;
    logic [CNTW-1:0]   r_cnt;
    logic              do_push, do_pop;

    assign o_full   = (r_cnt == CNTW'(FIFO_DEPTH));
    assign o_nempty = (r_cnt != '0);
    assign o_data   = r_mem[r_rptr];
    assign do_push  = i_push && !o_full;
    assign do_pop   = i_pop && o_nempty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_data;
        end
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= r_wptr + PW'(1);
            end
            if (do_pop) begin
                r_rptr <= r_rptr + PW'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + CNTW'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - CNTW'(1);
            end
        end
    end

endmodule
`default_nettype wire

[hw/rtl/gbsm_front.sv]
// front end: raster position tracking and item classification
`default_nettype none
module gbsm_front #(
    parameter int MAX_WIDTH = gbsm_pkg::DEF_MAX_WIDTH
) (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_rst_n,
    input  wire logic                                    i_valid,
    output logic                                         o_ready,
    input  wire logic [gbsm_pkg::PIX_W-1:0]              i_pixel,
    input  wire logic                                    i_frame_start,
    input  wire logic [$clog2(MAX_WIDTH+1)-1:0]          i_width,
    input  wire logic [gbsm_pkg::IMG_H_W-1:0]            i_height,
    input  wire logic                                    i_full,
    output logic                                         o_push,
    output logic [gbsm_pkg::PIX_W-1:0]                   o_pixel,
    output logic [$clog2(MAX_WIDTH)-1:0]                 o_col,
    output gbsm_pkg::t_flags                             o_flags
);
    import gbsm_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH + 1);
    localparam int AW = $clog2(MAX_WIDTH);

    logic [CW-1:0]      r_col, n_col;
    logic [ROW_W-1:0]   r_row, n_row;
    logic [CW-1:0]      c0, c;
    logic [IMG_H_W-1:0] r0, r1, rn;
    logic [CW-1:0]      cn;

    always_comb begin
        c0 = i_frame_start ? '0 : r_col;
        r0 = i_frame_start ? '0 : IMG_H_W'(r_row);
        if (c0 >= i_width) begin
            c  = '0;
            r1 = r0 + IMG_H_W'(1);
        end else begin
            c  = c0;
            r1 = r0;
        end
        if (r1 >= i_height) begin
            r1 = '0;
        end
        cn = c + CW'(1);
        rn = r1;
        if (cn >= i_width) begin
            cn = '0;
            rn = r1 + IMG_H_W'(1);
            if (rn >= i_height) begin
                rn = '0;
            end
        end
        n_col = cn;
        n_row = rn[ROW_W-1:0];
    end

    assign o_ready         = !i_full;
    assign o_push          = i_valid && !i_full;
    assign o_pixel         = i_pixel;
    assign o_col           = c[AW-1:0];
    assign o_flags.rpar    = r1[0];
    assign o_flags.blur_en = (r1 >= IMG_H_W'(2)) && (c >= CW'(2));
    assign o_flags.sob_en  = (r1 >= IMG_H_W'(4)) && (c >= CW'(4));
    assign o_flags.last    = (r1 == i_height - IMG_H_W'(1)) && (c == i_width - CW'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (o_push) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

endmodule
`default_nettype wire

[hw/rtl/gbsm_back.sv]
// back end: line stores, blur accumulation, sobel, iterative root, output register
`default_nettype none
module gbsm_back #(
    parameter int MAX_WIDTH = gbsm_pkg::DEF_MAX_WIDTH
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_nempty,
    output logic                                       o_pop,
    input  wire logic [gbsm_pkg::PIX_W-1:0]            i_pixel,
    input  wire logic [$clog2(MAX_WIDTH)-1:0]          i_col,
    input  wire gbsm_pkg::t_flags                      i_flags,
    input  wire logic [gbsm_pkg::CFG_DATA_W-1:0]       i_coef0,
    input  wire logic [gbsm_pkg::CFG_DATA_W-1:0]       i_coef1,
    input  wire logic [gbsm_pkg::CFG_DATA_W-1:0]       i_coef2,
    output logic                                       o_valid,
    input  wire logic                                  i_ready,
    output logic [gbsm_pkg::OUT_TDATA_W-1:0]           o_data,
    output logic                                       o_last
);
    import gbsm_pkg::*;

    localparam int AW   = $clog2(MAX_WIDTH);
    localparam int ACCW = 28;
    localparam int SQW  = 38;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_RD   = 4'd1;
    localparam logic [3:0] S_MAC  = 4'd2;
    localparam logic [3:0] S_BV   = 4'd3;
    localparam logic [3:0] S_SOB  = 4'd4;
    localparam logic [3:0] S_SQX  = 4'd5;
    localparam logic [3:0] S_SQY  = 4'd6;
    localparam logic [3:0] S_ROOT = 4'd7;
    localparam logic [3:0] S_OUT  = 4'd8;

    logic [3:0] r_state;

    logic [PIX_W-1:0]  r_in0_mem [MAX_WIDTH];
    logic [PIX_W-1:0]  r_in1_mem [MAX_WIDTH];
    logic [BLUR_W-1:0] r_bl0_mem [MAX_WIDTH];
    logic [BLUR_W-1:0] r_bl1_mem [MAX_WIDTH];

    logic [PIX_W-1:0]  r_pix;
    logic [AW-1:0]     r_col;
    t_flags            r_flags;
    logic [PIX_W-1:0]  r_ird0, r_ird1;
    logic [BLUR_W-1:0] r_brd0, r_brd1;
    logic [PIX_W-1:0]  r_iw0 [3];
    logic [PIX_W-1:0]  r_iw1 [3];
    logic [BLUR_W-1:0] r_bw0 [3];
    logic [BLUR_W-1:0] r_bw1 [3];
    logic [3:0]        r_m;
    logic [ACCW-1:0]   r_acc;
    logic [BLUR_W-1:0] r_bv;
    logic [GRAD_W-1:0] r_gx, r_gy;
    logic [BLUR_W-1:0] r_bout;
    logic [SQW-1:0]    r_rem, r_res, r_bit;
    logic [4:0]        r_step;
    logic              r_ovalid;
    logic [OUT_TDATA_W-1:0] r_odata;
    logic              r_olast;

    logic [AW-1:0]     bj;
    logic [PIX_W-1:0]  icol [3];
    logic [BLUR_W-1:0] bc [3];
    logic [PIX_W-1:0]  opix [9];
    logic [COEF_W-1:0] owgt [9];
    logic [ACCW-1:0]   prod;
    logic [ACCW:0]     bsum;
    logic [GRAD_W-1:0] right, left, top, bot, gx, gy;
    logic [SQW-1:0]    trial;
    logic              out_free;

    assign bj      = r_col - AW'(2);
    assign icol[0] = r_flags.rpar ? r_ird1 : r_ird0;
    assign icol[1] = r_flags.rpar ? r_ird0 : r_ird1;
    assign icol[2] = r_pix;
    assign bc[0]   = r_flags.rpar ? r_brd1 : r_brd0;
    assign bc[1]   = r_flags.rpar ? r_brd0 : r_brd1;
    assign bc[2]   = r_bv;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            opix[3*k]   = r_iw1[k];
            opix[3*k+1] = r_iw0[k];
            opix[3*k+2] = icol[k];
        end
        for (int j = 0; j < 3; j++) begin
            owgt[j]   = i_coef0[COEF_W*j +: COEF_W];
            owgt[3+j] = i_coef1[COEF_W*j +: COEF_W];
            owgt[6+j] = i_coef2[COEF_W*j +: COEF_W];
        end
    end

    assign prod  = ACCW'(owgt[r_m] * opix[r_m]);
    assign bsum  = {1'b0, r_acc} + (ACCW+1)'(128);
    assign right = GRAD_W'(bc[0]) + {1'b0, bc[1], 1'b0} + GRAD_W'(bc[2]);
    assign left  = GRAD_W'(r_bw1[0]) + {1'b0, r_bw1[1], 1'b0} + GRAD_W'(r_bw1[2]);
    assign top   = GRAD_W'(r_bw1[0]) + {1'b0, r_bw0[0], 1'b0} + GRAD_W'(bc[0]);
    assign bot   = GRAD_W'(r_bw1[2]) + {1'b0, r_bw0[2], 1'b0} + GRAD_W'(bc[2]);
    assign gx    = (right >= left) ? right - left : left - right;
    assign gy    = (top >= bot) ? top - bot : bot - top;
    assign trial = r_res + r_bit;
    assign out_free = !r_ovalid || i_ready;

    assign o_pop   = (r_state == S_IDLE) && i_nempty;
    assign o_valid = r_ovalid;
    assign o_data  = r_odata;
    assign o_last  = r_olast;

    // line stores
    always_ff @(posedge i_clk) begin
        if (r_state == S_RD) begin
            r_ird0 <= r_in0_mem[r_col];
            r_ird1 <= r_in1_mem[r_col];
            r_brd0 <= r_bl0_mem[bj];
            r_brd1 <= r_bl1_mem[bj];
            if (r_flags.rpar) begin
                r_in1_mem[r_col] <= r_pix;
            end else begin
                r_in0_mem[r_col] <= r_pix;
            end
        end
        if (r_state == S_SOB) begin
            if (r_flags.rpar) begin
                r_bl1_mem[bj] <= r_bv;
            end else begin
                r_bl0_mem[bj] <= r_bv;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_pix   <= i_pixel;
                r_col   <= i_col;
                r_flags <= i_flags;
            end
            S_RD: begin
                r_acc <= '0;
                r_m   <= '0;
            end
            S_MAC: begin
                r_acc <= r_acc + prod;
                r_m   <= r_m + 4'd1;
            end
            S_BV: begin
                r_bv <= (|bsum[ACCW:24]) ? '1 : bsum[23:8];
            end
            S_SOB: begin
                r_gx   <= gx;
                r_gy   <= gy;
                r_bout <= r_bw0[1];
            end
            S_SQX: begin
                r_rem <= SQW'(r_gx * r_gx);
            end
            S_SQY: begin
                r_rem  <= r_rem + SQW'(r_gy * r_gy);
                r_res  <= '0;
                r_bit  <= SQW'(1) << 36;
                r_step <= '0;
            end
            S_ROOT: begin
                if (r_rem >= trial) begin
                    r_rem <= r_rem - trial;
                    r_res <= (r_res >> 1) + r_bit;
                end else begin
                    r_res <= r_res >> 1;
                end
                r_bit  <= r_bit >> 2;
                r_step <= r_step + 5'd1;
            end
            S_OUT: begin
            end
            default: begin
            end
        endcase
        if (r_state == S_OUT && out_free) begin
            r_odata <= {1'b0, r_res[MAG_W-1:0], r_gy, r_gx, r_bout};
            r_olast <= r_flags.last;
        end
    end

    // control and window state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            for (int k = 0; k < 3; k++) begin
                r_iw0[k] <= '0;
                r_iw1[k] <= '0;
                r_bw0[k] <= '0;
                r_bw1[k] <= '0;
            end
        end else begin
            // a result being handed over in S_OUT keeps valid set below
            if (r_ovalid && i_ready && (r_state != S_OUT)) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_nempty) begin
                        r_state <= S_RD;
                    end
                end
                S_RD: begin
                    r_state <= S_MAC;
                end
                S_MAC: begin
                    if (r_m == 4'd8) begin
                        r_state <= S_BV;
                    end
                end
                S_BV: begin
                    for (int k = 0; k < 3; k++) begin
                        r_iw1[k] <= r_iw0[k];
                        r_iw0[k] <= icol[k];
                    end
                    r_state <= r_flags.blur_en ? S_SOB : S_IDLE;
                end
                S_SOB: begin
                    for (int k = 0; k < 3; k++) begin
                        r_bw1[k] <= r_bw0[k];
                        r_bw0[k] <= bc[k];
                    end
                    r_state <= r_flags.sob_en ? S_SQX : S_IDLE;
                end
                S_SQX: begin
                    r_state <= S_SQY;
                end
                S_SQY: begin
                    r_state <= S_ROOT;
                end
                S_ROOT: begin
                    if (r_step == 5'd18) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        r_ovalid <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

[hw/rtl/gaussian_blur_sobel_magnitude.sv]
// top level: 3x3 blur followed by sobel gradient magnitude on a pixel stream
//
// usage
//   slave stream carries one grey pixel per item, tuser marks the first pixel
//   of a frame. master stream carries one result per interior blurred position:
//   blurred value, |gx|, |gy| and floor sqrt(gx^2 + gy^2); tlast flags the
//   result of the frame's final pixel. pixels that fall on the borders give
//   no result.
//   config channel writes image width, height and the three kernel rows; it is
//   always ready and is meant to be written while no pixel is in flight.
// back-end sequence
//   each pixel runs through a sequencer in the back end: one line store read,
//   a multiply-accumulate over the nine window taps on a single 16x8
//   multiplier and a blur step; a blurred pixel then takes a sobel step, and
//   a pixel with a result squares both gradients and runs a 2-bit-per-step root.
//   the four-item queue lets the slave side keep accepting while the back end
//   is busy.
// reset and stall
//   synchronous active-low reset clears position counters, windows, queue and
//   output valid; config returns to its defaults. line stores are not cleared.
//   a stalled master holds the result; the back end waits with the next one
//   and the queue fills up, then tready drops.
`default_nettype none
module gaussian_blur_sobel_magnitude #(
    parameter int MAX_WIDTH = gbsm_pkg::DEF_MAX_WIDTH
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // pixel input
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    input  wire logic [7:0]                          s_axis_tdata,  // [7:0] pixel
    input  wire logic                                s_axis_tuser,  // [0] frame_start
    // result output
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    // [15:0] blurred, [33:16] grad_x, [51:34] grad_y, [70:52] magnitude, [71] zero
    output logic [gbsm_pkg::OUT_TDATA_W-1:0]         m_axis_tdata,
    output logic                                     m_axis_tlast,  // last_of_frame
    // config write channel
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [gbsm_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [gbsm_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import gbsm_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH + 1);
    localparam int AW = $clog2(MAX_WIDTH);
    localparam int QW = PIX_W + AW + FLAGS_W;

    logic [IMG_W_W-1:0]    r_width;
    logic [IMG_H_W-1:0]    r_height;
    logic [CFG_DATA_W-1:0] r_coef0, r_coef1, r_coef2;

    logic [CW-1:0]      w_eff;
    logic [IMG_H_W-1:0] h_eff;

    logic               f_push, q_full, q_nempty, q_pop;
    logic [PIX_W-1:0]   f_pixel;
    logic [AW-1:0]      f_col;
    t_flags             f_flags;
    logic [QW-1:0]      q_in, q_out;
    logic [PIX_W-1:0]   b_pixel;
    logic [AW-1:0]      b_col;
    t_flags             b_flags;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= RST_IMAGE_WIDTH;
            r_height <= RST_IMAGE_HEIGHT;
            r_coef0  <= RST_COEF_ROW0;
            r_coef1  <= RST_COEF_ROW1;
            r_coef2  <= RST_COEF_ROW2;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_IMAGE_WIDTH:  r_width  <= i_cfg_data[IMG_W_W-1:0];
                REG_IMAGE_HEIGHT: r_height <= i_cfg_data[IMG_H_W-1:0];
                REG_COEF_ROW0:    r_coef0  <= i_cfg_data;
                REG_COEF_ROW1:    r_coef1  <= i_cfg_data;
                REG_COEF_ROW2:    r_coef2  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // dimensions saturate into their legal range
    always_comb begin
        if (32'(r_width) < 32'(MIN_DIM)) begin
            w_eff = CW'(MIN_DIM);
        end else if (32'(r_width) > 32'(MAX_WIDTH)) begin
            w_eff = CW'(MAX_WIDTH);
        end else begin
            w_eff = CW'(r_width);
        end
        if (r_height < IMG_H_W'(MIN_DIM)) begin
            h_eff = IMG_H_W'(MIN_DIM);
        end else if (32'(r_height) > 32'(MAX_HEIGHT)) begin
            h_eff = IMG_H_W'(MAX_HEIGHT);
        end else begin
            h_eff = r_height;
        end
    end

    gbsm_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_pixel      (s_axis_tdata),
        .i_frame_start(s_axis_tuser),
        .i_width      (w_eff),
        .i_height     (h_eff),
        .i_full       (q_full),
        .o_push       (f_push),
        .o_pixel      (f_pixel),
        .o_col        (f_col),
        .o_flags      (f_flags)
    );

    assign q_in = {f_flags, f_col, f_pixel};
    assign {b_flags, b_col, b_pixel} = q_out;

    gbsm_fifo #(.DATA_W(QW)) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_data  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_nempty(q_nempty),
        .o_data  (q_out)
    );

    gbsm_back #(.MAX_WIDTH(MAX_WIDTH)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_nempty(q_nempty),
        .o_pop   (q_pop),
        .i_pixel (b_pixel),
        .i_col   (b_col),
        .i_flags (b_flags),
        .i_coef0 (r_coef0),
        .i_coef1 (r_coef1),
        .i_coef2 (r_coef2),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (m_axis_tdata),
        .o_last  (m_axis_tlast)
    );

endmodule
`default_nettype wire

[hw/rtl/gbsm_checker.sv]
// port-level checks for the blur and gradient block, bound to the top level
`default_nettype none
module gbsm_checker (
    input wire logic                                i_clk,
    input wire logic                                i_rst_n,
    input wire logic                                s_axis_tvalid,
    input wire logic                                s_axis_tready,
    input wire logic [7:0]                          s_axis_tdata,
    input wire logic                                s_axis_tuser,
    input wire logic                                m_axis_tvalid,
    input wire logic                                m_axis_tready,
    input wire logic [gbsm_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    input wire logic                                m_axis_tlast,
    input wire logic                                i_cfg_valid,
    input wire logic                                o_cfg_ready,
    input wire logic [gbsm_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input wire logic [gbsm_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    logic [17:0] gx, gy;
    logic [18:0] mag;

    assign gx  = m_axis_tdata[33:16];
    assign gy  = m_axis_tdata[51:34];
    assign mag = m_axis_tdata[70:52];

    // no result right after reset
    a_rst_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tlast))
        else $error("stalled result changed");

    // root is at least each gradient
    a_mag_lo: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (mag >= {1'b0, gx}) && (mag >= {1'b0, gy}))
        else $error("magnitude below a gradient");

    // root never exceeds the sum of the gradients
    a_mag_hi: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> mag <= ({1'b0, gx} + {1'b0, gy}))
        else $error("magnitude above gradient sum");

endmodule

bind gaussian_blur_sobel_magnitude gbsm_checker u_gbsm_checker (.*);
`default_nettype wire

[bench/tb_gaussian_blur_sobel_magnitude.sv]
// testbench for the blur and sobel magnitude block: directed frames, then random frames
`timescale 1ns / 100ps
module tb_gaussian_blur_sobel_magnitude;
    import gbsm_pkg::*;

    localparam int CYCLE_LIMIT = 4000000;
    localparam int TARGET_ITEMS = 1450;
    localparam int DRAIN_CYCLES = 200;

    // one result item as seen on the master stream
    typedef struct packed {
        logic [BLUR_W-1:0] blurred;
        logic [GRAD_W-1:0] grad_x;
        logic [GRAD_W-1:0] grad_y;
        logic [MAG_W-1:0]  magnitude;
        logic              last;
    } t_grad;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [7:0] s_axis_tdata = '0;
    logic s_axis_tuser = 1'b0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic m_axis_tlast;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    always #1 i_clk = ~i_clk;

    gaussian_blur_sobel_magnitude dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    // shadow of the block: configuration, line stores, windows, position
    logic [IMG_W_W-1:0]    cfg_width;
    logic [IMG_H_W-1:0]    cfg_height;
    logic [CFG_DATA_W-1:0] cfg_kernel [3];
    logic [7:0]            pix_rows [2][DEF_MAX_WIDTH];
    logic [15:0]           blur_rows [2][DEF_MAX_WIDTH];
    logic [7:0]            pix_win [3][2];
    logic [15:0]           blur_win [3][2];
    int unsigned           col_pos, row_pos;

    t_grad grad_queue [$];
    int    mismatches = 0;
    int    items_sent = 0;
    longint cycles = 0;
    bit    quiet = 1'b0;     // no idling on either side while set
    int    stall_left = 0;

    // 5x5 directed frame: extremes, mostly in a checker pattern, one interior result
    logic [7:0] dir_pix [25] = '{
        8'd0, 8'd255, 8'd0, 8'd255, 8'd0,
        8'd255, 8'd0, 8'd255, 8'd0, 8'd255,
        8'd0, 8'd255, 8'd255, 8'd255, 8'd0,
        8'd255, 8'd0, 8'd255, 8'd0, 8'd255,
        8'd1, 8'd128, 8'd127, 8'd254, 8'd255
    };
    // under an all-zero kernel everything is zero, flagged as last of frame
    localparam t_grad ZERO_KERNEL_RESULT = '{blurred: '0, grad_x: '0, grad_y: '0,
                                             magnitude: '0, last: 1'b1};

    function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
        if (v < MIN_DIM) return MIN_DIM;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic longint unsigned floor_root(longint unsigned v);
        longint unsigned root = 0;
        for (int b = 20; b >= 0; b--) begin
            if ((root | (64'd1 << b)) * (root | (64'd1 << b)) <= v) root |= 64'd1 << b;
        end
        return root;
    endfunction

    function automatic longint unsigned absdiff(longint unsigned a, longint unsigned b);
        return a >= b ? a - b : b - a;
    endfunction

    // advance the shadow by one pixel; queue the gradient result if one is due
    task automatic predict_pixel(input logic [7:0] pix, input logic fs,
                                 input bit use_typed, input t_grad typed);
        int unsigned w, h, r, c, bi, bj;
        longint unsigned acc, bv, right, left, top, bot, gx, gy;
        logic [7:0] pcol [3];
        logic [15:0] bcol [3];
        t_grad res;
        w = clamp_dim(cfg_width, DEF_MAX_WIDTH);
        h = clamp_dim(cfg_height, MAX_HEIGHT);
        if (fs) begin
            col_pos = 0;
            row_pos = 0;
        end
        if (col_pos >= w) begin
            col_pos = 0;
            row_pos++;
        end
        if (row_pos >= h) row_pos = 0;
        r = row_pos;
        c = col_pos;
        pcol[0] = pix_rows[r & 1][c];
        pcol[1] = pix_rows[(r + 1) & 1][c];
        pcol[2] = pix;
        pix_rows[r & 1][c] = pix;
        if (r >= 2 && c >= 2) begin
            acc = 0;
            for (int k = 0; k < 3; k++) begin
                acc += cfg_kernel[k][15:0] * pix_win[k][1] + cfg_kernel[k][31:16] * pix_win[k][0]
                     + cfg_kernel[k][47:32] * pcol[k];
            end
            bv = (acc + 128) >> 8;
            if (bv > 65535) bv = 65535;
            bi = r - 2;
            bj = c - 2;
            bcol[0] = blur_rows[bi & 1][bj];
            bcol[1] = blur_rows[(bi + 1) & 1][bj];
            bcol[2] = bv[15:0];
            blur_rows[bi & 1][bj] = bv[15:0];
            if (bi >= 2 && bj >= 2) begin
                right = bcol[0] + 2 * bcol[1] + bcol[2];
                left = blur_win[0][1] + 2 * blur_win[1][1] + blur_win[2][1];
                top = blur_win[0][1] + 2 * blur_win[0][0] + bcol[0];
                bot = blur_win[2][1] + 2 * blur_win[2][0] + bcol[2];
                gx = absdiff(right, left);
                gy = absdiff(top, bot);
                res.blurred = blur_win[1][0];
                res.grad_x = gx[GRAD_W-1:0];
                res.grad_y = gy[GRAD_W-1:0];
                res.magnitude = MAG_W'(floor_root(gx * gx + gy * gy));
                res.last = (r == h - 1 && c == w - 1);
                grad_queue.push_back(use_typed ? typed : res);
            end
            for (int k = 0; k < 3; k++) begin
                blur_win[k][1] = blur_win[k][0];
                blur_win[k][0] = bcol[k];
            end
        end
        for (int k = 0; k < 3; k++) begin
            pix_win[k][1] = pix_win[k][0];
            pix_win[k][0] = pcol[k];
        end
        col_pos = c + 1;
        if (col_pos >= w) begin
            col_pos = 0;
            row_pos = r + 1;
            if (row_pos >= h) row_pos = 0;
        end
    endtask

    // mostly short gaps, now and then a long one
    function automatic int gap_len();
        int sel;
        if (quiet) return 0;
        sel = $urandom_range(0, 99);
        if (sel < 60) return 0;
        if (sel < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // one pixel item on the slave stream, with an optional gap before it
    task automatic send_pixel(input logic [7:0] pix, input logic fs,
                              input bit use_typed = 1'b0, input t_grad typed = '0);
        int gap;
        gap = gap_len();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= pix;
        s_axis_tuser <= fs;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predict_pixel(pix, fs, use_typed, typed);
        items_sent++;
    endtask

    // let every expected result come out, then let border pixels settle
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (grad_queue.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // register write; the block must be idle
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        case (idx)
            REG_IMAGE_WIDTH: cfg_width = val[IMG_W_W-1:0];
            REG_IMAGE_HEIGHT: cfg_height = val[IMG_H_W-1:0];
            REG_COEF_ROW0: cfg_kernel[0] = val;
            REG_COEF_ROW1: cfg_kernel[1] = val;
            REG_COEF_ROW2: cfg_kernel[2] = val;
            default: ;
        endcase
    endtask

    task automatic write_kernel(input logic [CFG_DATA_W-1:0] k0, input logic [CFG_DATA_W-1:0] k1,
                                input logic [CFG_DATA_W-1:0] k2);
        write_reg(REG_COEF_ROW0, k0);
        write_reg(REG_COEF_ROW1, k1);
        write_reg(REG_COEF_ROW2, k2);
    endtask

    // kernel row with weights that mostly keep the blur out of saturation
    function automatic logic [CFG_DATA_W-1:0] rand_kernel_row(bit full);
        logic [CFG_DATA_W-1:0] row;
        for (int i = 0; i < 3; i++) begin
            row[16*i +: 16] = full ? 16'($urandom()) : 16'($urandom_range(0, 7281));
        end
        return row;
    endfunction

    function automatic logic [7:0] rand_pixel();
        case ($urandom_range(0, 7))
            0: return 8'd0;
            1: return 8'd255;
            default: return 8'($urandom());
        endcase
    endfunction

    // result checker and receiver stalls
    always @(posedge i_clk) begin
        t_grad got, want;
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL gaussian_blur_sobel_magnitude");
            $finish;
        end
        if (m_axis_tvalid && m_axis_tready) begin
            got.blurred = m_axis_tdata[15:0];
            got.grad_x = m_axis_tdata[33:16];
            got.grad_y = m_axis_tdata[51:34];
            got.magnitude = m_axis_tdata[70:52];
            got.last = m_axis_tlast;
            if (grad_queue.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result item %h", got);
            end else begin
                want = grad_queue.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch: blurred %0d/%0d gx %0d/%0d gy %0d/%0d mag %0d/%0d last %0b/%0b (exp/act)",
                                 want.blurred, got.blurred, want.grad_x, got.grad_x,
                                 want.grad_y, got.grad_y, want.magnitude, got.magnitude,
                                 want.last, got.last);
                    end
                end
            end
        end
        if (stall_left > 0) begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
            if ($urandom_range(0, 5) == 0) stall_left = gap_len();
        end
    end

    initial begin
        int w, h, frames;
        bit fs_first;
        cfg_width = RST_IMAGE_WIDTH;
        cfg_height = RST_IMAGE_HEIGHT;
        cfg_kernel[0] = RST_COEF_ROW0;
        cfg_kernel[1] = RST_COEF_ROW1;
        cfg_kernel[2] = RST_COEF_ROW2;
        col_pos = 0;
        row_pos = 0;
        pix_win = '{default: '0};
        blur_win = '{default: '0};
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: smallest frame, zero kernel, then saturating kernel, then default kernel
        write_reg(REG_IMAGE_WIDTH, 5);
        write_reg(REG_IMAGE_HEIGHT, 5);
        write_kernel('0, '0, '0);
        for (int i = 0; i < 25; i++) send_pixel(dir_pix[i], i == 0, i == 24, ZERO_KERNEL_RESULT);
        wait_idle();
        write_kernel('1, '1, '1);
        for (int i = 0; i < 25; i++) send_pixel(dir_pix[i], i == 0);
        wait_idle();
        write_kernel(RST_COEF_ROW0, RST_COEF_ROW1, RST_COEF_ROW2);
        for (int i = 0; i < 25; i++) send_pixel(dir_pix[i], i == 0);
        wait_idle();

        // widest row: width saturates to the maximum and wraps into the next row,
        // height below the minimum clamps up
        write_reg(REG_IMAGE_WIDTH, 11'h7ff);
        write_reg(REG_IMAGE_HEIGHT, 0);
        quiet = 1'b1;
        for (int i = 0; i < DEF_MAX_WIDTH + 8; i++) send_pixel(rand_pixel(), i == 0);
        quiet = 1'b0;
        wait_idle();

        // tallest frame: only a few rows, abandoned by the next frame start
        write_reg(REG_IMAGE_WIDTH, 0);
        write_reg(REG_IMAGE_HEIGHT, 13'h1fff);
        for (int i = 0; i < 40; i++) send_pixel(rand_pixel(), i == 0);
        wait_idle();
        write_reg(REG_IMAGE_HEIGHT, MAX_HEIGHT);
        for (int i = 0; i < 40; i++) send_pixel(rand_pixel(), i == 0);
        wait_idle();

        // random phases of small frames up to the overall item budget
        while (items_sent < TARGET_ITEMS) begin
            w = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(5, 12);
            h = $urandom_range(5, 8);
            write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(w));
            write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(h));
            write_kernel(rand_kernel_row($urandom_range(0, 4) == 0),
                         rand_kernel_row($urandom_range(0, 4) == 0),
                         rand_kernel_row($urandom_range(0, 4) == 0));
            quiet = ($urandom_range(0, 4) == 0);
            frames = $urandom_range(1, 3);
            for (int f = 0; f < frames; f++) begin
                // later frames may rely on the position wrap instead of a frame start
                fs_first = (f == 0) || $urandom_range(0, 1);
                for (int i = 0; i < w * h; i++) begin
                    // rare stray frame start restarts the frame mid-way
                    send_pixel(rand_pixel(), (i == 0 && fs_first) || ($urandom_range(0, 199) == 0));
                end
            end
            quiet = 1'b0;
            wait_idle();
        end

        if (mismatches == 0 && grad_queue.size() == 0) begin
            $display("PASS gaussian_blur_sobel_magnitude");
        end else begin
            $display("FAIL gaussian_blur_sobel_magnitude");
        end
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/gbsm_pkg.sv
hw/rtl/gbsm_fifo.sv
hw/rtl/gbsm_front.sv
hw/rtl/gbsm_back.sv
hw/rtl/gaussian_blur_sobel_magnitude.sv
hw/rtl/gbsm_checker.sv
bench/tb_gaussian_blur_sobel_magnitude.sv
